>>> src/mpool_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared types and constants of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mpool_pkg;

  localparam int MAX_POOL     = 4;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_CHANNELS = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int SLOT_BITS  = $clog2(MAX_POOL);
  localparam int ROW_BITS   = 12;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int CHAN_BITS  = $clog2(MAX_CHANNELS);
  localparam int ADDR_BITS  = SLOT_BITS + COL_BITS + CHAN_BITS;
  localparam int STORE_DEPTH = MAX_POOL * MAX_WIDTH * MAX_CHANNELS;

  // configuration register widths
  localparam int POOL_BITS  = 3;
  localparam int HGT_BITS   = 13;
  localparam int WID_BITS   = 9;
  localparam int CCNT_BITS  = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_POOL_HEIGHT   = 3'd0,
    REG_POOL_WIDTH    = 3'd1,
    REG_STRIDE_ROWS   = 3'd2,
    REG_STRIDE_COLS   = 3'd3,
    REG_IN_HEIGHT     = 3'd4,
    REG_IN_WIDTH      = 3'd5,
    REG_CHANNEL_COUNT = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_WAIT,
    B_DONE
  } bstate_t;

  // one pending window: bottom row slot, first column, channel, size, labels
  typedef struct packed {
    logic [SLOT_BITS-1:0] rbot;
    logic [COL_BITS-1:0]  col0;
    logic [CHAN_BITS-1:0] chan;
    logic [SLOT_BITS-1:0] ph_m1;
    logic [SLOT_BITS-1:0] pw_m1;
    logic [ROW_BITS-1:0]  oh;
    logic [COL_BITS-1:0]  ow;
    logic                 done;
  } job_t;

  // store location the front is about to overwrite
  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic [COL_BITS-1:0]  col;
    logic [CHAN_BITS-1:0] chan;
  } probe_t;

endpackage
`default_nettype wire

>>> src/mpool_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpool_sample_if
// Input channel: one feature sample with its frame start mark.
// ----------------------------------------------------------------------------
interface mpool_sample_if;
  import mpool_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface
`default_nettype wire

>>> src/mpool_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpool_result_if
// Output channel: one window maximum with its position.
// ----------------------------------------------------------------------------
interface mpool_result_if;
  import mpool_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [ROW_BITS-1:0]           out_row;
  logic [COL_BITS-1:0]           out_col;
  logic [CHAN_BITS-1:0]          channel;
  logic                          frame_done;

  modport source (output valid, output max_value, output out_row, output out_col,
                  output channel, output frame_done, input ready);
  modport sink   (input valid, input max_value, input out_row, input out_col,
                  input channel, input frame_done, output ready);
endinterface
`default_nettype wire

>>> src/mpool_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpool_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mpool_cfg_if;
  import mpool_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/max_pool_2d_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2-D max pooling with valid padding over a channel-fastest map.
// ----------------------------------------------------------------------------
// Channels: feature takes one sample per item in row, column, channel order;
// frame_start on an item restarts the map at row 0, column 0, channel 0.
// pooled gives one item per finished window: the maximum, its output row and
// column, the channel, and frame_done on the last result of the map. cfg
// writes register 0..6 (pool height, pool width, row stride, column stride,
// map height, map width, channel count); values are clamped, and any write to them
// restarts the position counters. Write cfg only while the block is idle.
// Timing: samples that finish no window are taken one per cycle unless the
// front stalls. A finished window goes into a two-entry queue; the back end
// takes one window at a time and scans it with one line store read per
// cycle, then presents its result before it starts on the next window. The
// front stalls while the queue is full or the incoming sample would overwrite
// a line store entry that a queued window or the window being scanned still
// has to read.
// Reset clears counters, queue and result register and loads the default
// registers (2, 2, 2, 2, 256, 256, 16); the line store needs no clearing.
// When pooled stalls, the result holds and the queue then the input fill up.
// ----------------------------------------------------------------------------
module max_pool_2d_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  mpool_cfg_if.sink       cfg,
  mpool_sample_if.sink    feature,
  mpool_result_if.source  pooled
);
  import mpool_pkg::*;

  probe_t                 probe;
  job_t                   job;
  logic                   push, take_ok;
  logic                   st_we, st_re;
  logic [ADDR_BITS-1:0]   st_waddr, st_raddr;
  logic [SAMPLE_BITS-1:0] st_wdata, st_rdata;

  mpool_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .feature  (feature),
    .take_ok  (take_ok),
    .probe    (probe),
    .push     (push),
    .job      (job),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata)
  );

  mpool_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mpool_back u_back (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .job_in   (job),
    .probe    (probe),
    .take_ok  (take_ok),
    .st_re    (st_re),
    .st_raddr (st_raddr),
    .st_rdata (st_rdata),
    .pooled   (pooled)
  );

endmodule
`default_nettype wire

>>> src/mpool_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpool_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpool_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/mpool_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpool_front
// Takes configuration writes and samples, writes samples to the line store,
// tracks the map position and stride phases, and issues completed windows.
// ----------------------------------------------------------------------------
module mpool_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  mpool_cfg_if.sink                              cfg,
  mpool_sample_if.sink                           feature,
  input  wire logic                              take_ok,
  output      mpool_pkg::probe_t                 probe,
  output      logic                              push,
  output      mpool_pkg::job_t                   job,
  output      logic                              st_we,
  output      logic [mpool_pkg::ADDR_BITS-1:0]   st_waddr,
  output      logic [mpool_pkg::SAMPLE_BITS-1:0] st_wdata
);
  import mpool_pkg::*;

  logic [POOL_BITS-1:0] pool_h, pool_w, str_r, str_c;
  logic [HGT_BITS-1:0]  height;
  logic [WID_BITS-1:0]  width;
  logic [CCNT_BITS-1:0] chans;

  logic [ROW_BITS-1:0]  row_cnt, row_cnt_next;
  logic [COL_BITS-1:0]  col_cnt, col_cnt_next;
  logic [CHAN_BITS-1:0] chan_cnt, chan_cnt_next;
  logic [POOL_BITS-1:0] row_ph, row_ph_next, col_ph, col_ph_next;
  logic [ROW_BITS-1:0]  oh, oh_next;
  logic [COL_BITS-1:0]  ow, ow_next;

  logic [ROW_BITS-1:0]  r_cur;
  logic [COL_BITS-1:0]  c_cur;
  logic [CHAN_BITS-1:0] d_cur;
  logic [POOL_BITS-1:0] rph_cur, cph_cur;
  logic [ROW_BITS-1:0]  oh_cur;
  logic [COL_BITS-1:0]  ow_cur;

  logic acc, cfg_hit;
  logic row_in, col_in, chan_wrap, col_wrap, row_wrap;
  logic [POOL_BITS-1:0] pool_h_m1, pool_w_m1;

  logic [2:0]           v3;
  logic [HGT_BITS-1:0]  v_h;
  logic [WID_BITS-1:0]  v_w;
  logic [CCNT_BITS-1:0] v_c;

  assign cfg.ready     = 1'b1;
  assign feature.ready = take_ok;
  assign acc           = feature.valid && take_ok;

  assign v3  = cfg.data[2:0];
  assign v_h = cfg.data[HGT_BITS-1:0];
  assign v_w = cfg.data[WID_BITS-1:0];
  assign v_c = cfg.data[CCNT_BITS-1:0];

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg.index)
      REG_POOL_HEIGHT, REG_POOL_WIDTH, REG_STRIDE_ROWS, REG_STRIDE_COLS,
      REG_IN_HEIGHT, REG_IN_WIDTH, REG_CHANNEL_COUNT: cfg_hit = cfg.valid;
      default: cfg_hit = 1'b0;
    endcase
  end

  // register writes, clamped to the legal ranges
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_h <= POOL_BITS'(2);
      pool_w <= POOL_BITS'(2);
      str_r  <= POOL_BITS'(2);
      str_c  <= POOL_BITS'(2);
      height <= HGT_BITS'(256);
      width  <= WID_BITS'(256);
      chans  <= CCNT_BITS'(MAX_CHANNELS);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_POOL_HEIGHT:
          pool_h <= (v3 == 3'd0) ? 3'd1 : (v3 > 3'(MAX_POOL)) ? 3'(MAX_POOL) : v3;
        REG_POOL_WIDTH:
          pool_w <= (v3 == 3'd0) ? 3'd1 : (v3 > 3'(MAX_POOL)) ? 3'(MAX_POOL) : v3;
        REG_STRIDE_ROWS: str_r <= (v3 == 3'd0) ? 3'd1 : v3;
        REG_STRIDE_COLS: str_c <= (v3 == 3'd0) ? 3'd1 : v3;
        REG_IN_HEIGHT:
          height <= (v_h == '0) ? HGT_BITS'(1) :
                    (v_h > HGT_BITS'(HEIGHT_LIMIT)) ? HGT_BITS'(HEIGHT_LIMIT) : v_h;
        REG_IN_WIDTH:
          width <= (v_w == '0) ? WID_BITS'(1) :
                   (v_w > WID_BITS'(MAX_WIDTH)) ? WID_BITS'(MAX_WIDTH) : v_w;
        REG_CHANNEL_COUNT:
          chans <= (v_c == '0) ? CCNT_BITS'(1) :
                   (v_c > CCNT_BITS'(MAX_CHANNELS)) ? CCNT_BITS'(MAX_CHANNELS) : v_c;
        default: ;
      endcase
    end
  end

  // position of the incoming sample; frame start restarts the map
  always_comb begin
    r_cur   = feature.frame_start ? '0 : row_cnt;
    c_cur   = feature.frame_start ? '0 : col_cnt;
    d_cur   = feature.frame_start ? '0 : chan_cnt;
    rph_cur = feature.frame_start ? '0 : row_ph;
    cph_cur = feature.frame_start ? '0 : col_ph;
    oh_cur  = feature.frame_start ? '0 : oh;
    ow_cur  = feature.frame_start ? '0 : ow;
  end

  assign pool_h_m1 = pool_h - 3'd1;
  assign pool_w_m1 = pool_w - 3'd1;

  assign row_in    = ({1'b0, r_cur} + 13'd1) >= HGT_BITS'(pool_h);
  assign col_in    = ({1'b0, c_cur} + 9'd1) >= WID_BITS'(pool_w);
  assign chan_wrap = ({1'b0, d_cur} + 5'd1) >= chans;
  assign col_wrap  = chan_wrap && (({1'b0, c_cur} + 9'd1) >= width);
  assign row_wrap  = col_wrap && (({1'b0, r_cur} + 13'd1) >= height);

  assign probe.slot = r_cur[SLOT_BITS-1:0];
  assign probe.col  = c_cur;
  assign probe.chan = d_cur;

  assign st_we    = acc;
  assign st_waddr = {r_cur[SLOT_BITS-1:0], c_cur, d_cur};
  assign st_wdata = feature.sample;

  // a window ends here when its origin sits on both stride grids
  assign push = acc && row_in && col_in && (rph_cur == '0) && (cph_cur == '0);

  always_comb begin
    job.rbot  = r_cur[SLOT_BITS-1:0];
    job.col0  = c_cur - COL_BITS'(pool_w_m1);
    job.chan  = d_cur;
    job.ph_m1 = pool_h_m1[SLOT_BITS-1:0];
    job.pw_m1 = pool_w_m1[SLOT_BITS-1:0];
    job.oh    = oh_cur;
    job.ow    = ow_cur;
    job.done  = (({1'b0, r_cur} + HGT_BITS'(str_r)) >= height) &&
                (({1'b0, c_cur} + WID_BITS'(str_c)) >= width) &&
                (({1'b0, d_cur} + 5'd1) == chans);
  end

  // advance channel, column and row with their stride phases
  always_comb begin
    chan_cnt_next = chan_wrap ? '0 : d_cur + 4'd1;
    col_cnt_next  = c_cur;
    col_ph_next   = cph_cur;
    ow_next       = ow_cur;
    row_cnt_next  = r_cur;
    row_ph_next   = rph_cur;
    oh_next       = oh_cur;
    if (col_wrap) begin
      col_cnt_next = '0;
      col_ph_next  = '0;
      ow_next      = '0;
      if (row_wrap) begin
        row_cnt_next = '0;
        row_ph_next  = '0;
        oh_next      = '0;
      end else begin
        row_cnt_next = r_cur + 12'd1;
        if (row_in) begin
          if (rph_cur == str_r - 3'd1) begin
            row_ph_next = '0;
            oh_next     = oh_cur + 12'd1;
          end else begin
            row_ph_next = rph_cur + 3'd1;
          end
        end else begin
          row_ph_next = '0;
          oh_next     = '0;
        end
      end
    end else if (chan_wrap) begin
      col_cnt_next = c_cur + 8'd1;
      if (col_in) begin
        if (cph_cur == str_c - 3'd1) begin
          col_ph_next = '0;
          ow_next     = ow_cur + 8'd1;
        end else begin
          col_ph_next = cph_cur + 3'd1;
        end
      end else begin
        col_ph_next = '0;
        ow_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      chan_cnt <= '0;
      row_ph   <= '0;
      col_ph   <= '0;
      oh       <= '0;
      ow       <= '0;
    end else if (acc) begin
      row_cnt  <= row_cnt_next;
      col_cnt  <= col_cnt_next;
      chan_cnt <= chan_cnt_next;
      row_ph   <= row_ph_next;
      col_ph   <= col_ph_next;
      oh       <= oh_next;
      ow       <= ow_next;
    end
  end

endmodule
`default_nettype wire

>>> src/mpool_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpool_back
// Two-entry window queue and a read sequencer that scans each window in the
// line store, one entry per cycle, and keeps the running maximum.
// ----------------------------------------------------------------------------
module mpool_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire mpool_pkg::job_t                   job_in,
  input  wire mpool_pkg::probe_t                 probe,
  output      logic                              take_ok,
  output      logic                              st_re,
  output      logic [mpool_pkg::ADDR_BITS-1:0]   st_raddr,
  input  wire logic [mpool_pkg::SAMPLE_BITS-1:0] st_rdata,
  mpool_result_if.source                         pooled
);
  import mpool_pkg::*;

  job_t    q [2];
  logic    qv [2];
  logic    wp, rp;
  logic    pop, hazard, last_rd, load_out;
  bstate_t state, state_next;
  job_t    cur;
  logic [SLOT_BITS-1:0] h, w;
  logic    rd_pend, first;
  logic signed [SAMPLE_BITS-1:0] best, rd_val;

  // true when a write to location s would clobber an entry of window p
  function automatic logic overlaps(input job_t p, input probe_t s);
    logic [SLOT_BITS-1:0] dslot;
    logic [COL_BITS:0]    col_hi;
    dslot  = p.rbot - s.slot;
    col_hi = {1'b0, p.col0} + (COL_BITS+1)'(p.pw_m1);
    return (dslot <= p.ph_m1) && (s.col >= p.col0) &&
           ({1'b0, s.col} <= col_hi) && (s.chan == p.chan);
  endfunction

  assign hazard = (qv[0] && overlaps(q[0], probe)) ||
                  (qv[1] && overlaps(q[1], probe)) ||
                  (((state == B_READ) || (state == B_WAIT)) && overlaps(cur, probe));
  assign take_ok = !(qv[0] && qv[1]) && !hazard;

  assign last_rd = (h == cur.ph_m1) && (w == cur.pw_m1);
  assign rd_val  = $signed(st_rdata);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (qv[rp]) state_next = B_READ;
      B_READ: if (last_rd) state_next = B_WAIT;
      B_WAIT: state_next = B_DONE;
      B_DONE: if (!pooled.valid || pooled.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    st_re    = 1'b0;
    load_out = 1'b0;
    case (state)
      B_IDLE: pop = qv[rp];
      B_READ: st_re = 1'b1;
      B_WAIT: ;
      B_DONE: load_out = !pooled.valid || pooled.ready;
      default: ;
    endcase
  end

  assign st_raddr = {cur.rbot - cur.ph_m1 + h, cur.col0 + COL_BITS'(w), cur.chan};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      qv[0] <= 1'b0;
      qv[1] <= 1'b0;
      wp    <= 1'b0;
      rp    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= st_re;
      if (push) begin
        qv[wp] <= 1'b1;
        wp     <= ~wp;
      end
      if (pop) begin
        qv[rp] <= 1'b0;
        rp     <= ~rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= job_in;
    end
    if (pop) begin
      cur   <= q[rp];
      h     <= '0;
      w     <= '0;
      first <= 1'b1;
    end else if (st_re) begin
      if (w == cur.pw_m1) begin
        w <= '0;
        h <= h + SLOT_BITS'(1);
      end else begin
        w <= w + SLOT_BITS'(1);
      end
    end
    if (rd_pend) begin
      first <= 1'b0;
      if (first || (rd_val > best)) begin
        best <= rd_val;
      end
    end
  end

  // result register: holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      pooled.valid <= 1'b0;
    end else if (load_out) begin
      pooled.valid <= 1'b1;
    end else if (pooled.ready) begin
      pooled.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pooled.max_value  <= best;
      pooled.out_row    <= cur.oh;
      pooled.out_col    <= cur.ow;
      pooled.channel    <= cur.chan;
      pooled.frame_done <= cur.done;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !(qv[0] && qv[1]))
    else $error("window pushed into a full queue");
  assert property (@(posedge clk) disable iff (rst) rd_pend == $past(state == B_READ))
    else $error("read data arrived without a read");
  assert property (@(posedge clk) disable iff (rst) load_out |=> pooled.valid)
    else $error("result not presented after window finished");
  assert property (@(posedge clk) disable iff (rst)
                   (state == B_DONE) |-> $past(state == B_WAIT) || $past(state == B_DONE))
    else $error("window finished without its last read");

endmodule
`default_nettype wire
